[src/hfd_pkg.sv]
// Package for the humidity/temperature frame decoder.
// Holds the CRC-8 step, scaling constants, the divide-by-65535 helper and
// the struct passed from the frame tracker to the result register.
package hfd_pkg;

  // CRC-8 of each sensor word: polynomial 0x31, preset 0xFF, MSB first.
  localparam logic [7:0] CRC_POLY = 8'h31;
  localparam logic [7:0] CRC_INIT = 8'hFF;
  localparam logic [7:0] CRC_MSB  = 8'h80;

  // Scaling: temperature = -4500 + 17500*raw/65535, humidity = 10000*raw/65535.
  localparam int unsigned TPROD_W = 31;
  localparam int unsigned HPROD_W = 30;
  localparam int unsigned QUOT_W  = 15;
  localparam int unsigned TEMP_W  = 15;
  localparam int unsigned HUM_W   = 14;

  localparam logic [TPROD_W-1:0] TEMP_SPAN   = TPROD_W'(17500);
  localparam logic [HPROD_W-1:0] HUM_SPAN    = HPROD_W'(10000);
  localparam logic [TEMP_W-1:0]  TEMP_OFFSET = TEMP_W'(4500);

  // Byte packing widths on the streams.
  localparam int unsigned IN_DATA_W  = 8;
  localparam int unsigned OUT_DATA_W = 32;

  // Status codes.
  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_ERR = 1'b1;

  // Summary of a completed frame, valid while the last byte is presented.
  typedef struct packed {
    logic               ok;
    logic [TPROD_W-1:0] temp_prod;
    logic [HPROD_W-1:0] hum_prod;
  } frame_done_t;

  // One byte through the bitwise CRC register, eight shifts.
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] r;
    r = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      if ((r & CRC_MSB) != 8'h00) begin
        r = (r << 1) ^ CRC_POLY;
      end else begin
        r = r << 1;
      end
    end
    return r;
  endfunction

  // floor(x / 65535) for quotients below 2^15: (x + (x >> 16) + 1) >> 16.
  function automatic logic [QUOT_W-1:0] div65535(input logic [TPROD_W-1:0] x);
    logic [TPROD_W:0] s;
    s = {1'b0, x} + (TPROD_W+1)'(x[TPROD_W-1:16]) + (TPROD_W+1)'(1);
    return s[16 +: QUOT_W];
  endfunction

endpackage

[src/hfd_in_reg.sv]
// Input register of the frame decoder: holds one received byte item.
// Depends on hfd_pkg for the stream data width.
module hfd_in_reg (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [hfd_pkg::IN_DATA_W-1:0] s_tdata,   // [7:0] data_byte
  input  logic                          s_tuser,   // [0] frame_start
  input  logic                          take,
  output logic                          valid,
  output logic [7:0]                    data_byte,
  output logic                          frame_start
);
  import hfd_pkg::*;

  // The register can be refilled in the same cycle that its item is taken.
  assign s_tready = !valid || take;

  // Valid flag under reset, payload loaded on every accepted item.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (s_tready) begin
      valid <= s_tvalid;
    end
    if (s_tvalid && s_tready) begin
      data_byte   <= s_tdata[7:0];
      frame_start <= s_tuser;
    end
  end

endmodule

[src/hfd_frame.sv]
// Frame tracker: byte position, running CRC-8 and scaled word products.
// Depends on hfd_pkg for the CRC step, scaling constants and frame_done_t.
module hfd_frame (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 valid,
  input  logic                 take,
  input  logic [7:0]           data_byte,
  input  logic                 frame_start,
  output logic                 emit,
  output hfd_pkg::frame_done_t done
);
  import hfd_pkg::*;

  typedef enum logic [2:0] {
    POS_T_MSB,
    POS_T_LSB,
    POS_T_CRC,
    POS_H_MSB,
    POS_H_LSB,
    POS_H_CRC
  } pos_t;

  pos_t               pos;
  pos_t               eff_pos;
  logic [7:0]         running_crc;
  logic [7:0]         temp_msb;
  logic [7:0]         hum_msb;
  logic               temp_crc_ok;
  logic [TPROD_W-1:0] temp_prod;
  logic [HPROD_W-1:0] hum_prod;
  logic [7:0]         crc_cont;
  logic [7:0]         crc_fresh;

  // A frame start always realigns to the first byte.
  assign eff_pos   = frame_start ? POS_T_MSB : pos;
  assign crc_cont  = crc8_byte(running_crc, data_byte);
  assign crc_fresh = crc8_byte(CRC_INIT, data_byte);

  // The humidity CRC byte closes the frame and produces a result.
  assign emit           = valid && (eff_pos == POS_H_CRC);
  assign done.ok        = temp_crc_ok && (running_crc == data_byte);
  assign done.temp_prod = temp_prod;
  assign done.hum_prod  = hum_prod;

  // Position and CRC state, with the words scaled as soon as they are whole.
  always_ff @(posedge clk) begin
    if (rst) begin
      pos         <= POS_T_MSB;
      running_crc <= CRC_INIT;
      temp_crc_ok <= 1'b0;
    end else if (take) begin
      unique case (eff_pos)
        POS_T_MSB: begin
          running_crc <= crc_fresh;
          pos         <= POS_T_LSB;
        end
        POS_T_LSB: begin
          running_crc <= crc_cont;
          pos         <= POS_T_CRC;
        end
        POS_T_CRC: begin
          temp_crc_ok <= (running_crc == data_byte);
          running_crc <= CRC_INIT;
          pos         <= POS_H_MSB;
        end
        POS_H_MSB: begin
          running_crc <= crc_fresh;
          pos         <= POS_H_LSB;
        end
        POS_H_LSB: begin
          running_crc <= crc_cont;
          pos         <= POS_H_CRC;
        end
        POS_H_CRC: begin
          running_crc <= CRC_INIT;
          pos         <= POS_T_MSB;
        end
        default: begin
          // Unused position codes behave as the first byte of a frame.
          running_crc <= crc_fresh;
          pos         <= POS_T_LSB;
        end
      endcase
    end
    // Payload registers.
    if (take) begin
      if (eff_pos == POS_T_MSB) begin
        temp_msb <= data_byte;
      end
      if (eff_pos == POS_T_LSB) begin
        temp_prod <= TEMP_SPAN * TPROD_W'({temp_msb, data_byte});
      end
      if (eff_pos == POS_H_MSB) begin
        hum_msb <= data_byte;
      end
      if (eff_pos == POS_H_LSB) begin
        hum_prod <= HUM_SPAN * HPROD_W'({hum_msb, data_byte});
      end
    end
  end

endmodule

[src/hfd_out_reg.sv]
// Result register: divides the scaled words by 65535 and holds the result item.
// Depends on hfd_pkg for div65535, the scaling constants and frame_done_t.
module hfd_out_reg (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           load,
  input  hfd_pkg::frame_done_t           done,
  output logic                           out_free,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [hfd_pkg::OUT_DATA_W-1:0] m_tdata,  // [14:0] temperature_centi, [28:15] humidity_centi
  output logic                           m_tuser   // [0] status
);
  import hfd_pkg::*;

  logic [QUOT_W-1:0] temp_quot;
  logic [QUOT_W-1:0] hum_quot;
  logic [TEMP_W-1:0] temp_centi;
  logic [HUM_W-1:0]  hum_centi;

  // Constant division and offset; both values read zero on a CRC error.
  assign temp_quot  = div65535(done.temp_prod);
  assign hum_quot   = div65535(TPROD_W'(done.hum_prod));
  assign temp_centi = done.ok ? (TEMP_W'(temp_quot) - TEMP_OFFSET) : '0;
  assign hum_centi  = done.ok ? hum_quot[HUM_W-1:0] : '0;

  assign out_free = !m_tvalid || m_tready;

  // Result item holding register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_free) begin
      m_tvalid <= load;
    end
    if (load && out_free) begin
      m_tuser <= done.ok ? STATUS_OK : STATUS_ERR;
      m_tdata <= {(OUT_DATA_W - TEMP_W - HUM_W)'(0), hum_centi, temp_centi};
    end
  end

endmodule

[src/humidity_temp_frame_decoder.sv]
// Top level of the humidity/temperature frame decoder.
// Depends on hfd_pkg, hfd_in_reg, hfd_frame and hfd_out_reg.
//
//  channel | direction | tdata                          | tuser
//  s_*     | in        | [7:0] data_byte                | [0] frame_start
//  m_*     | out       | [14:0] temp_centi, [28:15] hum | [0] status
//
// One byte item per cycle is sustained while the result register can accept a
// closing byte; each byte waits in the input register, and the frame result
// appears in the cycle after its last byte is processed.
// Synchronous reset clears the valid flags, the byte position and the CRC.
// A stalled result blocks only a closing byte; other bytes keep flowing.
module humidity_temp_frame_decoder (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [hfd_pkg::IN_DATA_W-1:0]  s_tdata,  // [7:0] data_byte
  input  logic                           s_tuser,  // [0] frame_start
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [hfd_pkg::OUT_DATA_W-1:0] m_tdata,  // [14:0] temperature_centi, [28:15] humidity_centi
  output logic                           m_tuser   // [0] status
);
  import hfd_pkg::*;

  logic        in_valid;
  logic [7:0]  in_byte;
  logic        in_start;
  logic        take;
  logic        emit;
  logic        out_free;
  frame_done_t done;

  // A byte is consumed unless it closes a frame while the result slot is full.
  assign take = in_valid && (!emit || out_free);

  hfd_in_reg u_in_reg (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .take        (take),
    .valid       (in_valid),
    .data_byte   (in_byte),
    .frame_start (in_start)
  );

  hfd_frame u_frame (
    .clk         (clk),
    .rst         (rst),
    .valid       (in_valid),
    .take        (take),
    .data_byte   (in_byte),
    .frame_start (in_start),
    .emit        (emit),
    .done        (done)
  );

  hfd_out_reg u_out_reg (
    .clk      (clk),
    .rst      (rst),
    .load     (take && emit),
    .done     (done),
    .out_free (out_free),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

`ifndef NO_ASSERTIONS
  // An error result carries zero values.
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser == STATUS_ERR) |-> (m_tdata == '0))
    else $error("error result with non-zero values");

  // A good humidity result never exceeds full scale.
  a_hum_range: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser == STATUS_OK) |-> (m_tdata[28:15] <= HUM_W'(10000)))
    else $error("humidity out of range");

  // A byte held back in the input register is kept unchanged.
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !take) |=> (in_valid && $stable(in_byte) && $stable(in_start)))
    else $error("held input byte lost or changed");
`endif

endmodule
